FILE: rtl/lrsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the linear ramp step pulse generator.
// No dependencies; every other file of the block uses this package.
package lrsp_pkg;

    // Field widths
    localparam int VEL_W    = 16;
    localparam int CNT_W    = 24;
    localparam int POS_W    = 32;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;

    // Timer ticks per second of the timebase
    localparam int TIMEBASE_TICKS = 1000000;

    // Serial multiplier: 32 x 32, one multiplier bit per cycle
    localparam int MUL_W     = 32;
    localparam int MUL_STEPS = MUL_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // Serial divider: restoring, one quotient bit per cycle
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 41;
    localparam int DIV_STEPS = DIV_NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int DLY_SHIFT = 40;
    localparam logic [DIV_NUM_W-1:0] DLY_NUM      = DIV_NUM_W'(1) << DLY_SHIFT;
    localparam logic [DIV_DEN_W-1:0] TIMEBASE_DEN = DIV_DEN_W'(TIMEBASE_TICKS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ0,
        S_SQ1,
        S_ACC_PREP,
        S_ACC_DIV,
        S_TINC_DIV,
        S_MUL_DV,
        S_VEL,
        S_DLY_DIV,
        S_ADV,
        S_DONE
    } t_state;

endpackage

FILE: rtl/lrsp_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the step pulse generator: input items and results.
// Depends on lrsp_pkg for the field widths.
interface lrsp_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    opcode;
    logic        [lrsp_pkg::VEL_W-1:0]       start_velocity;
    logic        [lrsp_pkg::VEL_W-1:0]       end_velocity;
    logic signed [lrsp_pkg::CNT_W-1:0]       step_count;

    modport source (output valid, opcode, start_velocity, end_velocity, step_count,
                    input ready);
    modport sink   (input valid, opcode, start_velocity, end_velocity, step_count,
                    output ready);
endinterface

interface lrsp_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    step_pulse;
    logic        [1:0]                       direction_code;
    logic        [lrsp_pkg::CNT_W-1:0]       steps_remaining;
    logic signed [lrsp_pkg::POS_W-1:0]       position;

    modport source (output valid, step_pulse, direction_code, steps_remaining, position,
                    input ready);
    modport sink   (input valid, step_pulse, direction_code, steps_remaining, position,
                    output ready);
endinterface

FILE: rtl/lrsp_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, 32 x 32 to 64 bits, one bit per cycle.
// Depends on lrsp_pkg.
module lrsp_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lrsp_pkg::MUL_W-1:0]       i_mcand,
    input  logic [lrsp_pkg::MUL_W-1:0]       i_mplier,
    output logic                             o_done,
    output logic [2*lrsp_pkg::MUL_W-1:0]     o_product
);
    import lrsp_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [MUL_CNT_W-1:0]   r_cnt;
    logic [MUL_W-1:0]       r_mcand;
    logic [MUL_W-1:0]       r_mplier;
    logic [2*MUL_W-1:0]     r_prod;
    logic [MUL_W:0]         w_sum;

    // Add the multiplicand into the upper half when the current bit is set
    assign w_sum = {1'b0, r_prod[2*MUL_W-1:MUL_W]}
                 + (r_mplier[0] ? {1'b0, r_mcand} : {(MUL_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - MUL_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_prod   <= '0;
        end else if (r_busy) begin
            r_mplier <= {1'b0, r_mplier[MUL_W-1:1]};
            r_prod   <= {w_sum, r_prod[MUL_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_prod;

endmodule

FILE: rtl/lrsp_div.sv
`timescale 1ns / 1ps
// Restoring divider, 48-bit dividend by 41-bit divisor, one quotient bit per cycle.
// Depends on lrsp_pkg.
module lrsp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lrsp_pkg::DIV_NUM_W-1:0]   i_dividend,
    input  logic [lrsp_pkg::DIV_DEN_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [lrsp_pkg::DIV_NUM_W-1:0]   o_quotient
);
    import lrsp_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_DEN_W-1:0]   r_den;
    logic [DIV_DEN_W-1:0]   r_rem;
    logic [DIV_NUM_W-1:0]   r_quo;
    logic [DIV_DEN_W:0]     w_shift;
    logic [DIV_DEN_W:0]     w_diff;
    logic                   w_fit;

    // Dividend bits leave at the top of r_quo while quotient bits enter at the bottom
    assign w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fit   = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/linear_ramp_step_pulse_generator.sv
`timescale 1ns / 1ps
// Top level of the linear ramp step pulse generator for one stepper axis.
// Depends on lrsp_pkg, lrsp_if, lrsp_mul and lrsp_div.
//
// Each accepted item yields exactly one result item. A load item (opcode 0)
// starts a segment from start speed v0, end speed v1 and a signed step count;
// it sets the direction, the steps to go, v0 in Q16.16, the acceleration
// (v1^2 - v0^2) / (2|x|) in signed Q16.16 and the time increment
// tick_period / 1e6 s in Q8.24, and clears elapsed time, delay and accumulator.
// A tick item (opcode 1) issues a step when the delay accumulator has reached
// the current step delay, then recomputes the delay as 2^40 / |v0 + a*t| and
// advances accumulator and elapsed time, both saturating. All arithmetic runs
// through one bit-serial 32-step multiplier and one 48-step restoring divider,
// used one after the other. From acceptance to the loading of the result
// register, a load with motion runs two squarings, the acceleration division
// and the time increment division; an idle load (zero count or zero speeds)
// runs two squarings and the time increment division and zeroes steps to go,
// v0 and acceleration; a tick with steps left runs one product a*t and one
// reciprocal division, or the product alone when the speed works out to zero;
// a tick at the end of a segment goes straight to the result. A result that
// still waits in the output register holds the next one back until taken. One
// item is processed at a time; the input is ready again as soon as the result
// sits in the output register, even if not yet taken. The input is not ready
// during reset. tick_period must only be written while no item is in flight.
module linear_ramp_step_pulse_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lrsp_pkg::PERIOD_W-1:0]     i_cfg_wdata,
    lrsp_in_if.sink                           i_item,
    lrsp_out_if.source                        o_result
);
    import lrsp_pkg::*;

    // Control and architectural state
    t_state                  r_state,        n_state;
    logic [PERIOD_W-1:0]     r_tick_period,  n_tick_period;
    logic [POS_W-1:0]        r_position,     n_position;
    logic [CNT_W-1:0]        r_steps_left,   n_steps_left;
    t_dir                    r_dir,          n_dir;
    logic [TIME_W-1:0]       r_elapsed,      n_elapsed;
    logic [TIME_W-1:0]       r_init_vel,     n_init_vel;
    logic signed [TIME_W-1:0] r_accel,       n_accel;
    logic [TIME_W-1:0]       r_step_delay,   n_step_delay;
    logic [TIME_W-1:0]       r_delay_acc,    n_delay_acc;
    logic [TIME_W-1:0]       r_time_inc,     n_time_inc;
    logic                    r_pulse,        n_pulse;
    logic                    r_out_valid,    n_out_valid;

    // Working registers of the current item
    logic [VEL_W-1:0]        r_v0,           n_v0;
    logic [VEL_W-1:0]        r_v1,           n_v1;
    logic [CNT_W-1:0]        r_mag,          n_mag;
    logic [MUL_W-1:0]        r_sq0,          n_sq0;
    logic [MUL_W:0]          r_diff,         n_diff;
    logic [DIV_DEN_W:0]      r_vel,          n_vel;

    // Result register
    logic                    r_res_pulse;
    logic [1:0]              r_res_dir;
    logic [CNT_W-1:0]        r_res_steps;
    logic [POS_W-1:0]        r_res_pos;
    logic                    w_res_load;

    // Shared arithmetic units
    logic                    w_mul_start;
    logic [MUL_W-1:0]        w_mul_a;
    logic [MUL_W-1:0]        w_mul_b;
    logic                    w_mul_done;
    logic [2*MUL_W-1:0]      w_mul_prod;
    logic                    w_div_start;
    logic [DIV_NUM_W-1:0]    w_div_num;
    logic [DIV_DEN_W-1:0]    w_div_den;
    logic                    w_div_done;
    logic [DIV_NUM_W-1:0]    w_div_quo;

    // Helpers
    logic                    w_in_acc;
    logic [CNT_W-1:0]        w_raw;
    logic [CNT_W-1:0]        w_raw_mag;
    logic [MUL_W-1:0]        w_accel_mag;
    logic [MUL_W-1:0]        w_diff_mag;
    logic [DIV_DEN_W:0]      w_vel_mag;
    logic [TIME_W-1:0]       w_quo_sat;
    logic [TIME_W:0]         w_acc_sum;
    logic [TIME_W:0]         w_ela_sum;
    logic [DLY_SHIFT-1:0]    w_dv;
    logic                    w_q_over_pos;
    logic                    w_q_over_neg;

    lrsp_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mul_a),
        .i_mplier  (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_prod)
    );

    lrsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign i_item.ready = i_rst_n && (r_state == S_IDLE);
    assign w_in_acc     = i_item.valid && i_item.ready;

    assign w_raw       = i_item.step_count;
    assign w_raw_mag   = w_raw[CNT_W-1] ? (~w_raw + CNT_W'(1)) : w_raw;
    assign w_accel_mag = r_accel[TIME_W-1] ? (~r_accel + TIME_W'(1)) : r_accel;
    assign w_diff_mag  = r_diff[MUL_W] ? MUL_W'(~r_diff + (MUL_W+1)'(1)) : r_diff[MUL_W-1:0];
    assign w_vel_mag   = r_vel[DIV_DEN_W] ? (~r_vel + (DIV_DEN_W+1)'(1)) : r_vel;
    assign w_dv        = w_mul_prod[2*MUL_W-1:24];

    // Saturate a divider quotient to 32 unsigned bits
    assign w_quo_sat    = (|w_div_quo[DIV_NUM_W-1:TIME_W]) ? '1 : w_div_quo[TIME_W-1:0];
    // Acceleration limits: +0x7FFFFFFF and -0x80000000
    assign w_q_over_pos = |w_div_quo[DIV_NUM_W-1:TIME_W-1];
    assign w_q_over_neg = (|w_div_quo[DIV_NUM_W-1:TIME_W])
                        || (w_div_quo[TIME_W-1] && (|w_div_quo[TIME_W-2:0]));

    assign w_acc_sum = {1'b0, r_delay_acc} + {1'b0, r_time_inc};
    assign w_ela_sum = {1'b0, r_elapsed} + {1'b0, r_time_inc};

    always_comb begin
        n_state       = r_state;
        n_tick_period = r_tick_period;
        n_position    = r_position;
        n_steps_left  = r_steps_left;
        n_dir         = r_dir;
        n_elapsed     = r_elapsed;
        n_init_vel    = r_init_vel;
        n_accel       = r_accel;
        n_step_delay  = r_step_delay;
        n_delay_acc   = r_delay_acc;
        n_time_inc    = r_time_inc;
        n_pulse       = r_pulse;
        n_v0          = r_v0;
        n_v1          = r_v1;
        n_mag         = r_mag;
        n_sq0         = r_sq0;
        n_diff        = r_diff;
        n_vel         = r_vel;
        n_out_valid   = r_out_valid && !o_result.ready;
        w_res_load    = 1'b0;
        w_mul_start   = 1'b0;
        w_mul_a       = '0;
        w_mul_b       = '0;
        w_div_start   = 1'b0;
        w_div_num     = '0;
        w_div_den     = '0;

        if (i_cfg_we) begin
            n_tick_period = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_pulse = 1'b0;
                    if (i_item.opcode == OP_LOAD) begin
                        // Latch the segment and start with v0 squared
                        n_v0         = i_item.start_velocity;
                        n_v1         = i_item.end_velocity;
                        n_mag        = w_raw_mag;
                        n_dir        = (w_raw == '0) ? DIR_STOP
                                     : (w_raw[CNT_W-1] ? DIR_REV : DIR_FWD);
                        n_elapsed    = '0;
                        n_step_delay = '0;
                        n_delay_acc  = '0;
                        w_mul_start  = 1'b1;
                        w_mul_a      = MUL_W'(i_item.start_velocity);
                        w_mul_b      = MUL_W'(i_item.start_velocity);
                        n_state      = S_SQ0;
                    end else if (r_steps_left == '0) begin
                        // Segment finished: clear the step pulse and hold everything else
                        n_state = S_DONE;
                    end else begin
                        if (r_delay_acc >= r_step_delay) begin
                            n_delay_acc  = r_delay_acc - r_step_delay;
                            n_steps_left = r_steps_left - CNT_W'(1);
                            n_pulse      = 1'b1;
                            case (r_dir)
                                DIR_FWD: n_position = r_position + POS_W'(1);
                                DIR_REV: n_position = r_position - POS_W'(1);
                                default: n_position = r_position;
                            endcase
                        end
                        // Speed change |a| * t uses the time before this tick
                        w_mul_start = 1'b1;
                        w_mul_a     = w_accel_mag;
                        w_mul_b     = r_elapsed;
                        n_state     = S_MUL_DV;
                    end
                end
            end

            S_SQ0: begin
                if (w_mul_done) begin
                    n_sq0       = w_mul_prod[MUL_W-1:0];
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_W'(r_v1);
                    w_mul_b     = MUL_W'(r_v1);
                    n_state     = S_SQ1;
                end
            end

            S_SQ1: begin
                if (w_mul_done) begin
                    n_diff  = {1'b0, w_mul_prod[MUL_W-1:0]} - {1'b0, r_sq0};
                    n_state = S_ACC_PREP;
                end
            end

            S_ACC_PREP: begin
                if ((r_mag != '0) && ((r_v0 != '0) || (r_v1 != '0))) begin
                    n_steps_left = r_mag;
                    n_init_vel   = {r_v0, 16'h0000};
                    w_div_start  = 1'b1;
                    w_div_num    = {w_diff_mag, 16'h0000};
                    w_div_den    = {16'h0000, r_mag, 1'b0};
                    n_state      = S_ACC_DIV;
                end else begin
                    // Idle segment: no steps, no motion
                    n_steps_left = '0;
                    n_init_vel   = '0;
                    n_accel      = '0;
                    w_div_start  = 1'b1;
                    w_div_num    = {8'h00, r_tick_period, 24'h000000};
                    w_div_den    = TIMEBASE_DEN;
                    n_state      = S_TINC_DIV;
                end
            end

            S_ACC_DIV: begin
                if (w_div_done) begin
                    if (r_diff[MUL_W]) begin
                        n_accel = w_q_over_neg ? 32'sh8000_0000
                                : (~w_div_quo[TIME_W-1:0] + TIME_W'(1));
                    end else begin
                        n_accel = w_q_over_pos ? 32'sh7FFF_FFFF : w_div_quo[TIME_W-1:0];
                    end
                    w_div_start = 1'b1;
                    w_div_num   = {8'h00, r_tick_period, 24'h000000};
                    w_div_den   = TIMEBASE_DEN;
                    n_state     = S_TINC_DIV;
                end
            end

            S_TINC_DIV: begin
                if (w_div_done) begin
                    n_time_inc = w_quo_sat;
                    n_state    = S_DONE;
                end
            end

            S_MUL_DV: begin
                if (w_mul_done) begin
                    if (r_accel[TIME_W-1]) begin
                        n_vel = {10'b0, r_init_vel} - {2'b0, w_dv};
                    end else begin
                        n_vel = {10'b0, r_init_vel} + {2'b0, w_dv};
                    end
                    n_state = S_VEL;
                end
            end

            S_VEL: begin
                if (w_vel_mag == '0) begin
                    n_step_delay = '0;
                    n_state      = S_ADV;
                end else begin
                    w_div_start = 1'b1;
                    w_div_num   = DLY_NUM;
                    w_div_den   = w_vel_mag[DIV_DEN_W-1:0];
                    n_state     = S_DLY_DIV;
                end
            end

            S_DLY_DIV: begin
                if (w_div_done) begin
                    n_step_delay = w_quo_sat;
                    n_state      = S_ADV;
                end
            end

            S_ADV: begin
                // Advance accumulator and elapsed time, saturating at all ones
                n_delay_acc = w_acc_sum[TIME_W] ? '1 : w_acc_sum[TIME_W-1:0];
                n_elapsed   = w_ela_sum[TIME_W] ? '1 : w_ela_sum[TIME_W-1:0];
                n_state     = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    w_res_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tick_period <= PERIOD_W'(100);
            r_position    <= '0;
            r_steps_left  <= '0;
            r_dir         <= DIR_STOP;
            r_elapsed     <= '0;
            r_init_vel    <= '0;
            r_accel       <= '0;
            r_step_delay  <= '0;
            r_delay_acc   <= '0;
            r_time_inc    <= '0;
            r_pulse       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_tick_period <= n_tick_period;
            r_position    <= n_position;
            r_steps_left  <= n_steps_left;
            r_dir         <= n_dir;
            r_elapsed     <= n_elapsed;
            r_init_vel    <= n_init_vel;
            r_accel       <= n_accel;
            r_step_delay  <= n_step_delay;
            r_delay_acc   <= n_delay_acc;
            r_time_inc    <= n_time_inc;
            r_pulse       <= n_pulse;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v0   <= n_v0;
        r_v1   <= n_v1;
        r_mag  <= n_mag;
        r_sq0  <= n_sq0;
        r_diff <= n_diff;
        r_vel  <= n_vel;
        if (w_res_load) begin
            r_res_pulse <= r_pulse;
            r_res_dir   <= r_dir;
            r_res_steps <= r_steps_left;
            r_res_pos   <= r_position;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.step_pulse      = r_res_pulse;
    assign o_result.direction_code  = r_res_dir;
    assign o_result.steps_remaining = r_res_steps;
    assign o_result.position        = r_res_pos;

endmodule
